// File: rtl/core/srvm_pkg.sv
package srvm_pkg;

  localparam int unsigned RegCountDef   = 32;
  localparam int unsigned StackDepthDef = 64;

  localparam logic [15:0] ProgSizeRst = 16'hFFFF;
  localparam logic [15:0] StartIpRst  = 16'h0000;

  typedef enum logic [4:0] {
    OP_HALT  = 5'd0,
    OP_DISP  = 5'd1,
    OP_PRINT = 5'd2,
    OP_PUSH  = 5'd3,
    OP_POP   = 5'd4,
    OP_MOV   = 5'd5,
    OP_CALL  = 5'd6,
    OP_RET   = 5'd7,
    OP_JMP   = 5'd8,
    OP_JZ    = 5'd9,
    OP_JPOS  = 5'd10,
    OP_JNEG  = 5'd11,
    OP_ADD   = 5'd12,
    OP_SUB   = 5'd13,
    OP_MUL   = 5'd14,
    OP_DIV   = 5'd15
  } op_e;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_FIN   = 3'd1,
    ST_STACK = 3'd2,
    ST_REG   = 3'd3,
    ST_INSTR = 3'd4,
    ST_OVF   = 3'd5,
    ST_DIV0  = 3'd6,
    ST_UNK   = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_REG   = 2'd1,
    KIND_STACK = 2'd2
  } kind_e;

  localparam logic CfgProgSize = 1'b0;
  localparam logic CfgStartIp  = 1'b1;

  typedef enum logic [1:0] {
    PATH_OUT  = 2'd0,
    PATH_LIST = 2'd1,
    PATH_AR   = 2'd2,
    PATH_DIV  = 2'd3
  } path_e;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_RA   = 9'b000000010,
    S_RB   = 9'b000000100,
    S_EX   = 9'b000001000,
    S_DIV  = 9'b000010000,
    S_AR   = 9'b000100000,
    S_LRD  = 9'b001000000,
    S_LOUT = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_e;

  typedef struct packed {
    logic ld;
    logic rd_a;
    logic rd_b;
    logic ex;
    logic dv;
    logic ar;
    logic lrd;
    logic lout;
    logic oacc;
  } cmd_t;

  typedef struct packed {
    path_e path;
    logic  div_done;
    logic  last;
  } sts_t;

endpackage

// File: rtl/core/srvm_ram.sv
module srvm_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/core/srvm_ctrl.sv
module srvm_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  srvm_pkg::sts_t     sts_i,
  output srvm_pkg::cmd_t     cmd_o
);

  srvm_pkg::state_e state_q, state_d;

  assign in_ready_o  = (state_q == srvm_pkg::S_IDLE);
  assign out_valid_o = (state_q == srvm_pkg::S_OUT);

  always_comb begin
    cmd_o      = '0;
    cmd_o.ld   = in_ready_o & in_valid_i;
    cmd_o.rd_a = (state_q == srvm_pkg::S_RA);
    cmd_o.rd_b = (state_q == srvm_pkg::S_RB);
    cmd_o.ex   = (state_q == srvm_pkg::S_EX);
    cmd_o.dv   = (state_q == srvm_pkg::S_DIV);
    cmd_o.ar   = (state_q == srvm_pkg::S_AR);
    cmd_o.lrd  = (state_q == srvm_pkg::S_LRD);
    cmd_o.lout = (state_q == srvm_pkg::S_LOUT);
    cmd_o.oacc = out_valid_o & out_ready_i;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      srvm_pkg::S_IDLE: if (in_valid_i) begin
        state_d = srvm_pkg::S_RA;
      end
      srvm_pkg::S_RA: state_d = srvm_pkg::S_RB;
      srvm_pkg::S_RB: state_d = srvm_pkg::S_EX;
      srvm_pkg::S_EX: begin
        unique case (sts_i.path)
          srvm_pkg::PATH_OUT:  state_d = srvm_pkg::S_OUT;
          srvm_pkg::PATH_LIST: state_d = srvm_pkg::S_LRD;
          srvm_pkg::PATH_AR:   state_d = srvm_pkg::S_AR;
          srvm_pkg::PATH_DIV:  state_d = srvm_pkg::S_DIV;
          default:             state_d = srvm_pkg::S_OUT;
        endcase
      end
      srvm_pkg::S_DIV: if (sts_i.div_done) begin
        state_d = srvm_pkg::S_AR;
      end
      srvm_pkg::S_AR:   state_d = srvm_pkg::S_OUT;
      srvm_pkg::S_LRD:  state_d = srvm_pkg::S_LOUT;
      srvm_pkg::S_LOUT: state_d = srvm_pkg::S_OUT;
      srvm_pkg::S_OUT: if (out_ready_i) begin
        state_d = sts_i.last ? srvm_pkg::S_IDLE : srvm_pkg::S_LRD;
      end
      default: state_d = srvm_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= srvm_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/core/srvm_dp.sv
module srvm_dp #(
  parameter int unsigned RegCount   = srvm_pkg::RegCountDef,
  parameter int unsigned StackDepth = srvm_pkg::StackDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  srvm_pkg::cmd_t      cmd_i,
  output srvm_pkg::sts_t      sts_o,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [15:0]         cfg_data_i,
  input  logic [4:0]          action_i,
  input  logic signed [31:0]  operand_a_i,
  input  logic signed [31:0]  operand_b_i,
  output logic [2:0]          status_o,
  output logic [1:0]          out_kind_o,
  output logic [5:0]          out_index_o,
  output logic signed [31:0]  out_value_o,
  output logic [15:0]         next_ip_o,
  output logic                last_o
);

  localparam int unsigned RaW = (RegCount > 1) ? $clog2(RegCount) : 1;
  localparam int unsigned SaW = $clog2(StackDepth);
  localparam int unsigned SpW = SaW + 1;

  logic [4:0]      op_q;
  logic [31:0]     a_q, b_q;
  logic [15:0]     psize_q, ip_q;
  logic [SpW-1:0]  sp_q, li_q, lo_q;
  logic [2:0]      stop_q;
  logic [31:0]     x_q, top_q;
  logic signed [63:0] res_q;
  logic [RegCount-1:0] rvld_q;
  logic            rv_q;

  logic [2:0]  st_q;
  logic [1:0]  kind_q;
  logic [5:0]  idx_q;
  logic [31:0] val_q;
  logic [15:0] nip_q;
  logic        last_q;

  logic [32:0] rem_q;
  logic [31:0] quo_q, den_q;
  logic [4:0]  cnt_q;
  logic        neg_q;

  // Register file.
  logic           r_we;
  logic [RaW-1:0] r_waddr, r_raddr;
  logic [31:0]    r_wdata, r_rdata, y;

  // Stack.
  logic           s_we;
  logic [SaW-1:0] s_waddr, s_raddr;
  logic [31:0]    s_wdata, s_rdata;

  srvm_ram #(.Width(32), .Depth(RegCount)) u_regs (
    .clk_i   (clk_i),
    .we_i    (r_we),
    .waddr_i (r_waddr),
    .wdata_i (r_wdata),
    .raddr_i (r_raddr),
    .rdata_o (r_rdata)
  );

  srvm_ram #(.Width(32), .Depth(StackDepth)) u_stack (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  assign y       = rv_q ? r_rdata : 32'd0;
  assign r_raddr = cmd_i.rd_b ? b_q[RaW-1:0] : a_q[RaW-1:0];
  assign r_waddr = a_q[RaW-1:0];
  assign s_raddr = cmd_i.lrd ? SaW'(li_q - SpW'(1)) : SaW'(sp_q - SpW'(1));

  // Common conditions.
  logic [16:0] ip17;
  logic [15:0] ip2, ip3;
  logic        ret_fits, room, ok_a, ok_b, tgt_bad, is_div;
  logic [16:0] ip3w;

  assign ip17     = {1'b0, ip_q} + 17'd2;
  assign ip3w     = {1'b0, ip_q} + 17'd3;
  assign ip2      = ip17[16] ? 16'hFFFF : ip17[15:0];
  assign ip3      = ip3w[16] ? 16'hFFFF : ip3w[15:0];
  assign ret_fits = ip17 < {1'b0, psize_q};
  assign room     = sp_q < SpW'(StackDepth - 1);
  assign ok_a     = a_q < 32'(RegCount);
  assign ok_b     = b_q < 32'(RegCount);
  assign tgt_bad  = a_q[31] | (a_q >= {16'd0, psize_q});
  assign is_div   = (op_q == srvm_pkg::OP_DIV);

  // Execute decision.
  logic              ex_stop;
  logic [2:0]        ex_st;
  logic [15:0]       ex_nip;
  srvm_pkg::path_e   ex_path;
  logic [1:0]        ex_kind;
  logic [5:0]        ex_idx;
  logic [31:0]       ex_val;
  logic              ex_rwe, ex_swe, ex_inc, ex_dec, ex_top_data, ex_push_ip;
  logic              take;
  logic signed [63:0] ex_res;
  logic signed [31:0] xs, ys;

  assign xs = x_q;
  assign ys = y;

  always_comb begin
    ex_stop     = 1'b0;
    ex_st       = srvm_pkg::ST_OK;
    ex_nip      = ip2;
    ex_path     = srvm_pkg::PATH_OUT;
    ex_kind     = srvm_pkg::KIND_NONE;
    ex_idx      = 6'd0;
    ex_val      = 32'd0;
    ex_rwe      = 1'b0;
    ex_swe      = 1'b0;
    ex_inc      = 1'b0;
    ex_dec      = 1'b0;
    ex_top_data = 1'b0;
    ex_push_ip  = 1'b0;
    take        = 1'b0;
    unique case (op_q)
      srvm_pkg::OP_JZ:   take = (top_q == 32'd0);
      srvm_pkg::OP_JPOS: take = !top_q[31] && (top_q != 32'd0);
      default:           take = top_q[31];
    endcase
    if (stop_q != srvm_pkg::ST_OK) begin
      ex_stop = 1'b1;
      ex_st   = stop_q;
    end else if (ip_q >= psize_q || op_q == srvm_pkg::OP_HALT) begin
      ex_stop = 1'b1;
      ex_st   = srvm_pkg::ST_FIN;
    end else begin
      unique case (op_q)
        srvm_pkg::OP_DISP: begin
          if (!ok_a) begin
            ex_stop = 1'b1; ex_st = srvm_pkg::ST_REG;
          end else begin
            ex_kind = srvm_pkg::KIND_REG;
            ex_idx  = a_q[5:0];
            ex_val  = x_q;
          end
        end
        srvm_pkg::OP_PRINT: begin
          if (32'(sp_q) < a_q) begin
            ex_stop = 1'b1; ex_st = srvm_pkg::ST_STACK;
          end else if (sp_q != '0) begin
            ex_path = srvm_pkg::PATH_LIST;
          end
        end
        srvm_pkg::OP_PUSH: begin
          if (!room) begin
            ex_stop = 1'b1; ex_st = srvm_pkg::ST_STACK;
          end else if (!ok_a) begin
            ex_stop = 1'b1; ex_st = srvm_pkg::ST_REG;
          end else begin
            ex_swe = 1'b1; ex_inc = 1'b1;
          end
        end
        srvm_pkg::OP_POP: begin
          if (sp_q == '0) begin
            ex_stop = 1'b1; ex_st = srvm_pkg::ST_STACK;
          end else if (!ok_a) begin
            ex_stop = 1'b1; ex_st = srvm_pkg::ST_REG;
          end else begin
            ex_rwe = 1'b1; ex_top_data = 1'b1; ex_dec = 1'b1;
          end
        end
        srvm_pkg::OP_MOV: begin
          if (!ok_a) begin
            ex_stop = 1'b1; ex_st = srvm_pkg::ST_REG;
          end else begin
            ex_rwe = 1'b1; ex_nip = ip3;
          end
        end
        srvm_pkg::OP_CALL: begin
          if (!room) begin
            ex_stop = 1'b1; ex_st = srvm_pkg::ST_STACK;
          end else if (!ret_fits) begin
            ex_stop = 1'b1; ex_st = srvm_pkg::ST_INSTR;
          end else begin
            ex_swe = 1'b1; ex_inc = 1'b1; ex_push_ip = 1'b1;
            ex_nip = (a_q[31:16] != 16'd0) ? 16'hFFFF : a_q[15:0];
          end
        end
        srvm_pkg::OP_RET: begin
          if (sp_q == '0) begin
            ex_stop = 1'b1; ex_st = srvm_pkg::ST_STACK;
          end else begin
            ex_dec = 1'b1;
            ex_nip = (top_q[31:16] != 16'd0) ? 16'hFFFF : top_q[15:0];
          end
        end
        srvm_pkg::OP_JMP: begin
          if (tgt_bad) begin
            ex_stop = 1'b1; ex_st = srvm_pkg::ST_INSTR;
          end else begin
            ex_nip = a_q[15:0];
          end
        end
        srvm_pkg::OP_JZ, srvm_pkg::OP_JPOS, srvm_pkg::OP_JNEG: begin
          if (sp_q == '0) begin
            ex_stop = 1'b1; ex_st = srvm_pkg::ST_STACK;
          end else if (tgt_bad || (!take && !ret_fits)) begin
            ex_stop = 1'b1; ex_st = srvm_pkg::ST_INSTR;
          end else begin
            ex_dec = 1'b1;
            ex_nip = take ? a_q[15:0] : ip2;
          end
        end
        srvm_pkg::OP_ADD, srvm_pkg::OP_SUB, srvm_pkg::OP_MUL, srvm_pkg::OP_DIV: begin
          if (!ok_a || !ok_b) begin
            ex_stop = 1'b1; ex_st = srvm_pkg::ST_REG;
          end else if (is_div && y == 32'd0) begin
            ex_stop = 1'b1; ex_st = srvm_pkg::ST_DIV0;
          end else if (is_div && x_q == 32'h8000_0000 && y == 32'hFFFF_FFFF) begin
            ex_stop = 1'b1; ex_st = srvm_pkg::ST_OVF;
          end else begin
            ex_path = is_div ? srvm_pkg::PATH_DIV : srvm_pkg::PATH_AR;
          end
        end
        default: begin
          ex_stop = 1'b1; ex_st = srvm_pkg::ST_UNK;
        end
      endcase
    end
    if (ex_stop) begin
      ex_nip = ip_q;
    end
  end

  always_comb begin
    unique case (op_q)
      srvm_pkg::OP_ADD: ex_res = 64'(xs) + 64'(ys);
      srvm_pkg::OP_SUB: ex_res = 64'(xs) - 64'(ys);
      default:          ex_res = xs * ys;
    endcase
  end

  // Arithmetic completion.
  logic [31:0]        q_fix;
  logic signed [63:0] ar_r;
  logic               ar_ovf, ar_stop;
  logic [2:0]         ar_st;

  assign q_fix  = neg_q ? (32'd0 - quo_q) : quo_q;
  assign ar_r   = is_div ? 64'($signed(q_fix)) : res_q;
  assign ar_ovf = (ar_r[63:31] != '0) && (ar_r[63:31] != '1);
  assign ar_stop = ar_ovf || !room;
  assign ar_st  = ar_ovf ? srvm_pkg::ST_OVF : srvm_pkg::ST_STACK;

  // Divider step.
  logic [32:0] rem_sh, diff;
  assign rem_sh = {rem_q[31:0], quo_q[31]};
  assign diff   = rem_sh - {1'b0, den_q};

  // Memory writes.
  assign r_we    = cmd_i.ex & ex_rwe;
  assign r_wdata = ex_top_data ? top_q : b_q;
  assign s_we    = (cmd_i.ex & ex_swe) | (cmd_i.ar & !ar_stop);
  assign s_waddr = sp_q[SaW-1:0];
  assign s_wdata = cmd_i.ar ? ar_r[31:0] : (ex_push_ip ? 32'(ip17) : x_q);

  assign sts_o.path     = ex_path;
  assign sts_o.div_done = (cnt_q == 5'd31);
  assign sts_o.last     = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      psize_q <= srvm_pkg::ProgSizeRst;
      ip_q    <= srvm_pkg::StartIpRst;
      sp_q    <= '0;
      stop_q  <= srvm_pkg::ST_OK;
      rvld_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == srvm_pkg::CfgProgSize) begin
          psize_q <= cfg_data_i;
        end else begin
          ip_q <= cfg_data_i;
        end
      end
      if (cmd_i.ex) begin
        if (ex_stop) begin
          stop_q <= ex_st;
        end else if (ex_path == srvm_pkg::PATH_OUT || ex_path == srvm_pkg::PATH_LIST) begin
          ip_q <= ex_nip;
        end
        if (ex_inc) begin
          sp_q <= sp_q + SpW'(1);
        end else if (ex_dec) begin
          sp_q <= sp_q - SpW'(1);
        end
        if (ex_rwe) begin
          rvld_q[r_waddr] <= 1'b1;
        end
      end
      if (cmd_i.ar) begin
        if (ar_stop) begin
          stop_q <= ar_st;
        end else begin
          ip_q <= ip3;
          sp_q <= sp_q + SpW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld) begin
      op_q <= action_i;
      a_q  <= operand_a_i;
      b_q  <= operand_b_i;
    end
    if (cmd_i.rd_a || cmd_i.rd_b) begin
      rv_q <= rvld_q[r_raddr];
    end
    if (cmd_i.rd_b) begin
      x_q   <= y;
      top_q <= s_rdata;
    end
    if (cmd_i.ex) begin
      res_q  <= ex_res;
      li_q   <= sp_q;
      lo_q   <= (a_q == 32'd0) ? '0 : SpW'(a_q - 32'd1);
      rem_q  <= '0;
      quo_q  <= x_q[31] ? (32'd0 - x_q) : x_q;
      den_q  <= y[31] ? (32'd0 - y) : y;
      neg_q  <= x_q[31] ^ y[31];
      cnt_q  <= '0;
      st_q   <= ex_st;
      kind_q <= ex_kind;
      idx_q  <= ex_idx;
      val_q  <= ex_val;
      nip_q  <= ex_nip;
      last_q <= 1'b1;
    end
    if (cmd_i.dv) begin
      cnt_q <= cnt_q + 5'd1;
      if (!diff[32]) begin
        rem_q <= diff;
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[30:0], 1'b0};
      end
    end
    if (cmd_i.ar) begin
      st_q   <= ar_stop ? ar_st : srvm_pkg::ST_OK;
      kind_q <= srvm_pkg::KIND_NONE;
      idx_q  <= 6'd0;
      val_q  <= 32'd0;
      nip_q  <= ar_stop ? ip_q : ip3;
      last_q <= 1'b1;
    end
    if (cmd_i.lout) begin
      st_q   <= srvm_pkg::ST_OK;
      kind_q <= srvm_pkg::KIND_STACK;
      idx_q  <= 6'(SaW'(li_q - SpW'(1)));
      val_q  <= s_rdata;
      nip_q  <= ip_q;
      last_q <= ((li_q - SpW'(1)) == lo_q);
    end
    if (cmd_i.oacc) begin
      li_q <= li_q - SpW'(1);
    end
  end

  assign status_o    = st_q;
  assign out_kind_o  = kind_q;
  assign out_index_o = idx_q;
  assign out_value_o = val_q;
  assign next_ip_o   = nip_q;
  assign last_o      = last_q;

endmodule

// File: rtl/core/stack_register_vm_executor.sv
// Executes one fetched instruction per request on the input channel
// (action_i, operand_a_i, operand_b_i). Each request gives one or more
// results on the output channel; last_o marks the final one, and next_ip_o
// tells where the next instruction must be fetched from.
// The block handles one request at a time: in_ready_o is high only while
// no request is in flight. A request passes two register file reads
// and an execute state before its first result; add, sub and mul then
// pass an arithmetic completion state, and div first runs a restoring
// divider that finds the signed quotient at one bit a cycle. A stack
// listing reads each stack entry once and waits for each result to be taken.
// Results are held in an output register until out_ready_i is high; while
// the receiver stalls, the block waits. At reset the register file reads
// as zero, the stack is empty, the instruction pointer is zero and the
// block is running. After any stop every request repeats the stop status.
// Configuration writes (index 0 program size, 1 start address, which also
// loads the instruction pointer) are taken in any cycle and must only be
// issued while no request is in flight.
module stack_register_vm_executor #(
  parameter int unsigned RegCount   = srvm_pkg::RegCountDef,
  parameter int unsigned StackDepth = srvm_pkg::StackDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [4:0]         action_i,
  input  logic signed [31:0] operand_a_i,
  input  logic signed [31:0] operand_b_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         status_o,
  output logic [1:0]         out_kind_o,
  output logic [5:0]         out_index_o,
  output logic signed [31:0] out_value_o,
  output logic [15:0]        next_ip_o,
  output logic               last_o
);

  srvm_pkg::cmd_t cmd;
  srvm_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  srvm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  srvm_dp #(
    .RegCount   (RegCount),
    .StackDepth (StackDepth)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .action_i    (action_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .status_o    (status_o),
    .out_kind_o  (out_kind_o),
    .out_index_o (out_index_o),
    .out_value_o (out_value_o),
    .next_ip_o   (next_ip_o),
    .last_o      (last_o)
  );

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import srvm_pkg::*;

  typedef struct {
    logic [2:0]  st;
    logic [1:0]  kind;
    logic [5:0]  idx;
    logic [31:0] val;
    logic [15:0] nip;
    logic        last;
  } vm_result_t;

  localparam int QuietLimit = 4000;
  localparam int HoldCycles = 300;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_index = 1'b0;
  logic [15:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [4:0]         action = '0;
  logic signed [31:0] operand_a = '0;
  logic signed [31:0] operand_b = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [2:0]         status;
  logic [1:0]         out_kind;
  logic [5:0]         out_index;
  logic signed [31:0] out_value;
  logic [15:0]        next_ip;
  logic               last;

  stack_register_vm_executor DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .action_i    (action),
    .operand_a_i (operand_a),
    .operand_b_i (operand_b),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .status_o    (status),
    .out_kind_o  (out_kind),
    .out_index_o (out_index),
    .out_value_o (out_value),
    .next_ip_o   (next_ip),
    .last_o      (last)
  );

  always #1 clk = ~clk;

  // Shadow machine state.
  logic [31:0] gpr [32];
  logic [31:0] vstack [64];
  int          vsp;
  int          vip;
  logic [2:0]  vstop;
  int          prog_size;
  int          start_addr;
  logic [31:0] gpr_bk [32];
  logic [31:0] vstack_bk [64];
  int          vsp_bk;
  int          vip_bk;
  logic [2:0]  vstop_bk;

  vm_result_t step_out[$];
  vm_result_t pending_results[$];

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_req = 0;
  int hold_cnt = 0;
  int fail_cnt = 0;
  int sent_cnt = 0;
  int checked_cnt = 0;
  int quiet_cnt = 0;

  function automatic void add_result(logic [2:0] st, logic [1:0] kind, int idx,
                                     logic [31:0] val, int nip, logic lst);
    vm_result_t r;
    r.st = st;
    r.kind = kind;
    r.idx = idx[5:0];
    r.val = val;
    r.nip = nip[15:0];
    r.last = lst;
    step_out.push_back(r);
  endfunction

  function automatic void stop_with(logic [2:0] code);
    vstop = code;
    add_result(code, KIND_NONE, 0, '0, vip, 1'b1);
  endfunction

  function automatic void advance(int nip);
    vip = nip;
    add_result(ST_OK, KIND_NONE, 0, '0, nip, 1'b1);
  endfunction

  function automatic int sat16(longint v);
    return (v > 65535) ? 65535 : int'(v);
  endfunction

  function automatic void execute_instr(logic [4:0] op, logic [31:0] ua, logic [31:0] ub);
    longint a, b, una, x, y, r, top;
    int ip2, ip3, lo;
    bit ret_fits, take, room;
    a = longint'($signed(ua));
    b = longint'($signed(ub));
    una = ua;
    ip2 = sat16(vip + 2);
    ip3 = sat16(vip + 3);
    ret_fits = (vip + 2) < prog_size;
    room = vsp < 63;
    step_out.delete();
    if (vstop != ST_OK) begin
      add_result(vstop, KIND_NONE, 0, '0, vip, 1'b1);
      return;
    end
    if (vip >= prog_size || op == OP_HALT) begin
      stop_with(ST_FIN);
      return;
    end
    case (op)
      OP_DISP: begin
        if (a < 0 || a > 31) stop_with(ST_REG);
        else begin
          vip = ip2;
          add_result(ST_OK, KIND_REG, int'(a), gpr[a], ip2, 1'b1);
        end
      end
      OP_PRINT: begin
        if (vsp < una) stop_with(ST_STACK);
        else if (vsp == 0) advance(ip2);
        else begin
          lo = (una == 0) ? 0 : int'(una) - 1;
          vip = ip2;
          for (int i = vsp; i > lo; i--) begin
            add_result(ST_OK, KIND_STACK, i - 1, vstack[i - 1], ip2, (i - 1) == lo);
          end
        end
      end
      OP_PUSH: begin
        if (!room) stop_with(ST_STACK);
        else if (a < 0 || a > 31) stop_with(ST_REG);
        else begin
          vstack[vsp] = gpr[a];
          vsp++;
          advance(ip2);
        end
      end
      OP_POP: begin
        if (vsp == 0) stop_with(ST_STACK);
        else if (a < 0 || a > 31) stop_with(ST_REG);
        else begin
          vsp--;
          gpr[a] = vstack[vsp];
          advance(ip2);
        end
      end
      OP_MOV: begin
        if (a < 0 || a > 31) stop_with(ST_REG);
        else begin
          gpr[a] = ub;
          advance(ip3);
        end
      end
      OP_CALL: begin
        if (!room) stop_with(ST_STACK);
        else if (!ret_fits) stop_with(ST_INSTR);
        else begin
          vstack[vsp] = vip + 2;
          vsp++;
          advance(sat16(una));
        end
      end
      OP_RET: begin
        if (vsp == 0) stop_with(ST_STACK);
        else begin
          vsp--;
          advance(sat16(longint'({32'b0, vstack[vsp]})));
        end
      end
      OP_JMP: begin
        if (a < 0 || a >= prog_size) stop_with(ST_INSTR);
        else advance(int'(a));
      end
      OP_JZ, OP_JPOS, OP_JNEG: begin
        if (vsp == 0) stop_with(ST_STACK);
        else if (a < 0 || a >= prog_size) stop_with(ST_INSTR);
        else begin
          top = longint'($signed(vstack[vsp - 1]));
          take = (op == OP_JZ) ? (top == 0) : ((op == OP_JPOS) ? (top > 0) : (top < 0));
          if (!take && !ret_fits) stop_with(ST_INSTR);
          else begin
            vsp--;
            advance(take ? int'(a) : ip2);
          end
        end
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
        if (a < 0 || a > 31 || b < 0 || b > 31) begin
          stop_with(ST_REG);
          return;
        end
        x = longint'($signed(gpr[a]));
        y = longint'($signed(gpr[b]));
        if (op == OP_DIV) begin
          if (y == 0) begin
            stop_with(ST_DIV0);
            return;
          end
          if (x == -64'sd2147483648 && y == -1) begin
            stop_with(ST_OVF);
            return;
          end
          r = x / y;
        end else begin
          r = (op == OP_ADD) ? x + y : ((op == OP_SUB) ? x - y : x * y);
          if (r > 64'sd2147483647 || r < -64'sd2147483648) begin
            stop_with(ST_OVF);
            return;
          end
        end
        if (!room) stop_with(ST_STACK);
        else begin
          vstack[vsp] = r[31:0];
          vsp++;
          advance(ip3);
        end
      end
      default: stop_with(ST_UNK);
    endcase
  endfunction

  // Tries an instruction on the shadow state and reports whether the machine
  // keeps running afterwards, leaving the state untouched.
  function automatic bit keeps_running(logic [4:0] op, logic [31:0] ua, logic [31:0] ub);
    bit ok;
    gpr_bk = gpr;
    vstack_bk = vstack;
    vsp_bk = vsp;
    vip_bk = vip;
    vstop_bk = vstop;
    execute_instr(op, ua, ub);
    ok = (vstop == ST_OK) && (vip < prog_size);
    gpr = gpr_bk;
    vstack = vstack_bk;
    vsp = vsp_bk;
    vip = vip_bk;
    vstop = vstop_bk;
    return ok;
  endfunction

  task automatic send_instr(input logic [4:0] op, input logic [31:0] ua, input logic [31:0] ub);
    if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    execute_instr(op, ua, ub);
    foreach (step_out[i]) pending_results.push_back(step_out[i]);
    in_valid <= 1'b1;
    action <= op;
    operand_a <= ua;
    operand_b <= ub;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_cnt++;
    @(negedge clk);
  endtask

  task automatic end_requests();
    in_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    wait (pending_results.size() == 0);
    repeat (45) @(negedge clk);
  endtask

  task automatic write_cfg(input logic idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CfgProgSize) prog_size = data;
    else begin
      start_addr = data;
      vip = data;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0;
      4: return $urandom_range(0, 40) - 20;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_running_instr();
    logic [4:0] op;
    logic [31:0] ua, ub;
    int tmax;
    bit found = 0;
    tmax = (prog_size - 1 < 300) ? prog_size - 1 : 300;
    for (int t = 0; t < 25 && !found; t++) begin
      op = $urandom_range(1, 15);
      ua = $urandom_range(0, 31);
      ub = $urandom_range(0, 31);
      case (op)
        OP_MOV: ub = pick_value();
        OP_PRINT: ua = ($urandom_range(3) == 0) ? 0 : $urandom_range(0, vsp);
        OP_CALL, OP_JMP, OP_JZ, OP_JPOS, OP_JNEG: ua = $urandom_range(0, tmax);
        OP_RET: begin
          ua = $urandom;
          ub = $urandom;
        end
        OP_DISP, OP_PUSH, OP_POP: ub = $urandom;
        default: ;
      endcase
      found = keeps_running(op, ua, ub);
    end
    if (!found) begin
      op = OP_JMP;
      ua = '0;
      ub = $urandom;
    end
    send_instr(op, ua, ub);
  endtask

  task automatic test_directed();
    send_instr(OP_MOV, 0, 32'h7FFF_FFFF);
    send_instr(OP_MOV, 1, 32'h8000_0000);
    send_instr(OP_MOV, 31, 32'hFFFF_FFFF);
    send_instr(OP_MOV, 2, 0);
    send_instr(OP_DISP, 0, 0);
    send_instr(OP_DISP, 31, 32'hFFFF_FFFF);
    send_instr(OP_PRINT, 0, 0);
    send_instr(OP_PUSH, 0, 0);
    send_instr(OP_PUSH, 1, 0);
    send_instr(OP_PUSH, 31, 0);
    send_instr(OP_PUSH, 2, 0);
    send_instr(OP_PRINT, 0, 0);
    send_instr(OP_PRINT, 2, 0);
    send_instr(OP_JZ, 20, 0);
    send_instr(OP_ADD, 1, 0);
    send_instr(OP_SUB, 2, 0);
    send_instr(OP_MUL, 31, 0);
    send_instr(OP_DIV, 0, 31);
    send_instr(OP_DIV, 1, 0);
    send_instr(OP_JPOS, 40, 0);
    send_instr(OP_JNEG, 100, 0);
    send_instr(OP_CALL, 200, 0);
    send_instr(OP_RET, 32'hDEAD_BEEF, 32'h8000_0001);
    send_instr(OP_POP, 3, 32'h7FFF_FFFF);
    send_instr(OP_JMP, 50, 32'hFFFF_FFFF);
    end_requests();
  endtask

  task automatic test_random(input int count, input int tx_pct, input int rx_pct);
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    repeat (count) send_running_instr();
    end_requests();
    wait_idle();
  endtask

  task automatic test_settings(input logic [15:0] psize, input logic [15:0] sip,
                               input int count);
    wait_idle();
    write_cfg(CfgProgSize, psize);
    write_cfg(CfgStartIp, sip);
    test_random(count, 12, 12);
  endtask

  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    hold_req = 1;
    repeat (20) send_running_instr();
    end_requests();
    wait_idle();
    repeat (10) send_running_instr();
    end_requests();
    wait_idle();
  endtask

  // Random instructions with no regard for the machine state; the first
  // failing one stops the machine and the rest must repeat its status.
  task automatic test_stop();
    logic [31:0] ua;
    tx_idle_pct = 12;
    rx_stall_pct = 12;
    repeat (25) begin
      ua = ($urandom_range(1) == 0) ? $urandom : $urandom_range(0, 40);
      send_instr($urandom_range(0, 31), ua, $urandom);
    end
    end_requests();
    wait_idle();
  endtask

  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_cnt = HoldCycles;
      hold_req = 0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      fail_cnt++;
    end
  endtask

  always @(posedge clk) begin
    vm_result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no request pending: status %0d", status);
        fail_cnt++;
      end else begin
        e = pending_results.pop_front();
        check_field("status", e.st, status);
        check_field("out_kind", e.kind, out_kind);
        check_field("out_index", e.idx, out_index);
        check_field("out_value", e.val, out_value);
        check_field("next_ip", e.nip, next_ip);
        check_field("last", e.last, last);
        checked_cnt++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cnt <= 0;
    end else if (rst_n) begin
      quiet_cnt <= quiet_cnt + 1;
      if (quiet_cnt >= QuietLimit) begin
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  initial begin
    foreach (gpr[i]) gpr[i] = '0;
    foreach (vstack[i]) vstack[i] = '0;
    vsp = 0;
    vstop = ST_OK;
    prog_size = ProgSizeRst;
    start_addr = StartIpRst;
    vip = start_addr;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_directed();
    wait_idle();
    test_random(70, 0, 0);
    test_random(40, 65, 0);
    test_settings(16'd1000, 16'd500, 0);
    test_random(35, 0, 65);
    test_settings(16'hFFFF, 16'hFFFE, 25);
    test_settings(16'd1, 16'd0, 10);
    test_settings(16'd40, 16'd0, 30);
    test_settings(16'hFFFF, 16'd0, 0);
    test_backpressure();
    test_stop();
    $display("Executed %0d instructions with %0d results checked across six settings.",
             sent_cnt, checked_cnt);
    $display("The run ended in stop status %0d after idle, stall and hold-off phases.",
             vstop);
    if (fail_cnt == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
